/* rtl/core/ffba_pkg.sv */
// ============================================================================
// ffba_pkg
// Shared types and constants for the first-fit block allocator.
// ============================================================================
`default_nettype none

package ffba_pkg;

    localparam int MAX_FREE_SEGS   = 16;
    localparam int MAX_LIVE_ALLOCS = 16;
    localparam int BLOCK_ADDR_BITS = 16;

    localparam int AW  = BLOCK_ADDR_BITS;
    localparam int LW  = BLOCK_ADDR_BITS + 1;
    localparam int FCW = $clog2(MAX_FREE_SEGS + 1);
    localparam int SIW = $clog2(MAX_FREE_SEGS);
    localparam int LIW = (MAX_LIVE_ALLOCS > 1) ? $clog2(MAX_LIVE_ALLOCS) : 1;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_NO_FIT    = 3'd1;
    localparam logic [2:0] ST_RANGE     = 3'd2;
    localparam logic [2:0] ST_NOT_ALLOC = 3'd3;
    localparam logic [2:0] ST_FULL      = 3'd4;

    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    // one free segment as held in a cell
    typedef struct packed {
        logic          vld;
        logic [AW-1:0] start;
        logic [LW-1:0] len;
    } seg_t;

    // command broadcast from the controller to every cell
    typedef enum logic [2:0] {
        CC_NONE,
        CC_INIT,
        CC_SHRINK,
        CC_REMOVE,
        CC_INSERT,
        CC_GROW
    } cell_op_t;

    typedef struct packed {
        cell_op_t       op;
        logic [FCW-1:0] pos;
        logic [AW-1:0]  start;
        logic [LW-1:0]  len;
    } cell_cmd_t;

endpackage

`default_nettype wire

/* rtl/core/ffba_cell.sv */
// ============================================================================
// ffba_cell
// One slot of the address-ordered free-segment chain.
// ============================================================================
`default_nettype none

module ffba_cell import ffba_pkg::*; (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic [FCW-1:0] idx,
    input  wire cell_cmd_t      cmd,
    input  wire seg_t           left_in,   // neighbor at idx-1
    input  wire seg_t           right_in,  // neighbor at idx+1
    output seg_t                seg_out
);

    seg_t seg_reg, seg_next;

    always_comb begin
        seg_next = seg_reg;
        unique case (cmd.op)
            CC_INIT: begin
                seg_next.vld = (idx == '0);
                seg_next.start = '0;
                seg_next.len = cmd.len;
            end
            CC_SHRINK, CC_GROW: begin
                if (idx == cmd.pos) begin
                    seg_next.start = cmd.start;
                    seg_next.len = cmd.len;
                end
            end
            CC_REMOVE: begin
                // shift down from the right neighbor
                if (idx >= cmd.pos) seg_next = right_in;
            end
            CC_INSERT: begin
                if (idx == cmd.pos) begin
                    seg_next.vld = 1'b1;
                    seg_next.start = cmd.start;
                    seg_next.len = cmd.len;
                end else if (idx > cmd.pos) begin
                    seg_next = left_in;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seg_reg.vld <= 1'b0;
        end else begin
            seg_reg.vld <= seg_next.vld;
        end
        seg_reg.start <= seg_next.start;
        seg_reg.len <= seg_next.len;
    end

    assign seg_out = seg_reg;

endmodule

`default_nettype wire

/* rtl/core/first_fit_block_allocator_top.sv */
// ============================================================================
// first_fit_block_allocator_top
// First-fit allocator over a chain of free-segment cells with coalescing.
// ============================================================================
// One transaction is handled at a time. An allocate walks the free chain one
// cell per cycle until the first segment large enough; the first allocate
// after reset first seeds the chain with the heap, capped at 65536 blocks. A
// free looks up the live table, walks the chain to its insertion point one
// cell per cycle and then merges or inserts. The walk over the cell chain
// sets the rate. The result sits in an output register; a new item is taken
// once that result has been handed off.
`default_nettype none

module first_fit_block_allocator_top import ffba_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_we,
    input  wire logic [16:0] cfg_wdata,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [39:0] s_tdata,  // func[0], size_blocks[17:1], addr_block[34:18]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata   // status[2:0], block_index[18:3]
);

    typedef enum logic [2:0] {
        S_IDLE, S_SEED, S_PREP, S_WALK, S_APPLY, S_DONE
    } state_t;

    state_t state_reg;
    logic [16:0] heap_reg;
    logic heap_ready_reg;
    logic func_reg;
    logic [16:0] size_reg;
    logic [16:0] addr_reg;
    logic [FCW-1:0] ptr_reg;
    logic [LIW-1:0] slot_reg;
    logic [LW-1:0] flen_reg;
    logic [LW:0]   prev_end_reg;
    logic          prev_vld_reg;
    logic [2:0] status_reg;
    logic [AW-1:0] index_reg;
    logic out_vld_reg;

    // double merge grows the left segment in a follow-up cycle
    logic dbl_reg;
    logic [LW-1:0] dbl_len_reg;

    logic [AW-1:0] live_start_reg [MAX_LIVE_ALLOCS];
    logic [LW-1:0] live_len_reg [MAX_LIVE_ALLOCS];
    logic [MAX_LIVE_ALLOCS-1:0] live_vld_reg;

    seg_t segs [MAX_FREE_SEGS];
    seg_t lefts [MAX_FREE_SEGS];
    seg_t rights [MAX_FREE_SEGS];
    cell_cmd_t cmd;

    genvar g;
    generate
        for (g = 0; g < MAX_FREE_SEGS; g++) begin : g_cell
            if (g == 0) begin : g_l0
                assign lefts[g] = '0;
            end else begin : g_l
                assign lefts[g] = segs[g-1];
            end
            if (g == MAX_FREE_SEGS - 1) begin : g_rN
                assign rights[g] = '0;
            end else begin : g_r
                assign rights[g] = segs[g+1];
            end
            ffba_cell u_cell (
                .aclk     (aclk),
                .aresetn  (aresetn),
                .idx      (FCW'(g)),
                .cmd      (cmd),
                .left_in  (lefts[g]),
                .right_in (rights[g]),
                .seg_out  (segs[g])
            );
        end
    endgenerate

    // free count is the number of valid cells (they stay packed at the low end)
    logic [FCW-1:0] fcount;
    always_comb begin
        fcount = '0;
        for (int i = 0; i < MAX_FREE_SEGS; i++) fcount = fcount + FCW'(segs[i].vld);
    end

    // live table lookups; the lowest matching entry wins
    logic [LIW-1:0] free_slot, hit_slot;
    logic have_free, have_hit;
    always_comb begin
        free_slot = '0; have_free = 1'b0;
        hit_slot = '0;  have_hit = 1'b0;
        for (int i = MAX_LIVE_ALLOCS - 1; i >= 0; i--) begin
            if (!live_vld_reg[i]) begin
                free_slot = LIW'(i); have_free = 1'b1;
            end
            if (live_vld_reg[i] && {1'b0, live_start_reg[i]} == addr_reg) begin
                hit_slot = LIW'(i); have_hit = 1'b1;
            end
        end
    end

    logic [16:0] usable;
    assign usable = (heap_reg > 17'(1 << AW)) ? 17'(1 << AW) : heap_reg;

    seg_t cur;
    logic ptr_in;
    assign ptr_in = (ptr_reg < FCW'(MAX_FREE_SEGS));
    assign cur = ptr_in ? segs[ptr_reg[SIW-1:0]] : '0;

    logic [LW:0] cur_end;
    assign cur_end = {1'b0, cur.start} + {1'b0, cur.len};

    // merge decision for a free at insertion point ptr_reg
    logic join_prev, join_next;
    assign join_prev = prev_vld_reg && prev_end_reg == {1'b0, addr_reg};
    assign join_next = cur.vld
        && ({1'b0, addr_reg} + {1'b0, flen_reg}) == {1'b0, 1'b0, cur.start};

    seg_t prv;
    logic [FCW-1:0] prv_ptr;
    assign prv_ptr = ptr_reg - FCW'(1);
    assign prv = (ptr_reg != '0) ? segs[prv_ptr[SIW-1:0]] : '0;

    always_comb begin
        cmd = '0;
        cmd.op = CC_NONE;
        cmd.pos = ptr_reg;
        unique case (state_reg)
            S_SEED: begin
                cmd.op = (usable != '0) ? CC_INIT : CC_NONE;
                cmd.len = usable;
                if (usable == '0) cmd.op = CC_REMOVE;  // drops cell 0 and shifts the rest down
                if (usable == '0) cmd.pos = '0;
            end
            S_WALK: begin
                if (!func_reg && cur.vld && cur.len >= size_reg) begin
                    if (cur.len == size_reg) begin
                        cmd.op = CC_REMOVE;
                    end else begin
                        cmd.op = CC_SHRINK;
                        cmd.start = cur.start + AW'(size_reg);
                        cmd.len = cur.len - size_reg;
                    end
                end
            end
            S_APPLY: begin
                if (join_prev && join_next) begin
                    cmd.op = CC_REMOVE;  // drop the right segment; left grows below
                end else if (join_prev) begin
                    cmd.op = CC_GROW;
                    cmd.pos = ptr_reg - FCW'(1);
                    cmd.start = prv.start;
                    cmd.len = prv.len + flen_reg;
                end else if (join_next) begin
                    cmd.op = CC_GROW;
                    cmd.start = AW'(addr_reg);
                    cmd.len = cur.len + flen_reg;
                end else if (fcount < FCW'(MAX_FREE_SEGS)) begin
                    cmd.op = CC_INSERT;
                    cmd.start = AW'(addr_reg);
                    cmd.len = flen_reg;
                end
            end
            S_DONE: begin
                // the double merge finishes here by growing the left neighbor
                if (dbl_reg) begin
                    cmd.op = CC_GROW;
                    cmd.start = cur.start;
                    cmd.len = dbl_len_reg;
                end
            end
            default: ;
        endcase
    end

    assign s_tready = (state_reg == S_IDLE) && !out_vld_reg;
    assign m_tvalid = out_vld_reg;
    assign m_tdata = {5'd0, index_reg, status_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            heap_reg <= 17'd65536;
            heap_ready_reg <= 1'b0;
            live_vld_reg <= '0;
            out_vld_reg <= 1'b0;
            dbl_reg <= 1'b0;
        end else begin
            if (cfg_we) heap_reg <= cfg_wdata;
            if (out_vld_reg && m_tready) out_vld_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE: begin
                    if (s_tvalid && s_tready) begin
                        func_reg <= s_tdata[0];
                        size_reg <= s_tdata[17:1];
                        addr_reg <= s_tdata[34:18];
                        ptr_reg <= '0;
                        prev_vld_reg <= 1'b0;
                        if (s_tdata[0] == FUNC_ALLOC && !heap_ready_reg) begin
                            state_reg <= S_SEED;
                        end else begin
                            state_reg <= S_PREP;
                        end
                    end
                end
                S_SEED: begin
                    heap_ready_reg <= 1'b1;
                    state_reg <= S_PREP;
                end
                S_PREP: begin
                    index_reg <= '0;
                    state_reg <= S_DONE;
                    if (func_reg == FUNC_ALLOC) begin
                        if (size_reg == '0) begin
                            status_reg <= ST_NO_FIT;
                        end else if (!have_free) begin
                            status_reg <= ST_FULL;
                        end else begin
                            slot_reg <= free_slot;
                            state_reg <= S_WALK;
                        end
                    end else begin
                        if (addr_reg >= heap_reg) begin
                            status_reg <= ST_RANGE;
                        end else if (!have_hit) begin
                            status_reg <= ST_NOT_ALLOC;
                        end else begin
                            slot_reg <= hit_slot;
                            flen_reg <= live_len_reg[hit_slot];
                            state_reg <= S_WALK;
                        end
                    end
                end
                S_WALK: begin
                    if (func_reg == FUNC_ALLOC) begin
                        if (!cur.vld) begin
                            status_reg <= ST_NO_FIT;
                            state_reg <= S_DONE;
                        end else if (cur.len >= size_reg) begin
                            live_start_reg[slot_reg] <= cur.start;
                            live_len_reg[slot_reg] <= size_reg;
                            live_vld_reg[slot_reg] <= 1'b1;
                            status_reg <= ST_OK;
                            index_reg <= cur.start;
                            state_reg <= S_DONE;
                        end else begin
                            ptr_reg <= ptr_reg + FCW'(1);
                        end
                    end else begin
                        if (cur.vld && {1'b0, cur.start} < addr_reg) begin
                            prev_vld_reg <= 1'b1;
                            prev_end_reg <= cur_end;
                            ptr_reg <= ptr_reg + FCW'(1);
                        end else begin
                            state_reg <= S_APPLY;
                        end
                    end
                end
                S_APPLY: begin
                    state_reg <= S_DONE;
                    if (!join_prev && !join_next && fcount >= FCW'(MAX_FREE_SEGS)) begin
                        status_reg <= ST_FULL;
                    end else begin
                        status_reg <= ST_OK;
                        live_vld_reg[slot_reg] <= 1'b0;
                        if (join_prev && join_next) begin
                            dbl_reg <= 1'b1;
                            dbl_len_reg <= prv.len + flen_reg + cur.len;
                            ptr_reg <= ptr_reg - FCW'(1);
                        end
                    end
                end
                S_DONE: begin
                    if (dbl_reg) begin
                        dbl_reg <= 1'b0;
                    end else begin
                        out_vld_reg <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_one_side: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid)) else $error("input taken while result pending");
    a_chain_count: assert property (@(posedge aclk) disable iff (!aresetn)
        fcount <= FCW'(MAX_FREE_SEGS)) else $error("free chain overflow");
    a_ok_alloc: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(out_vld_reg) && status_reg != ST_OK |-> index_reg == '0)
        else $error("index on failed result");
`endif

endmodule

`default_nettype wire

/* tb/tb.sv */
// ============================================================================
// First-fit block allocator testbench
// Drives allocate and free transactions through the stream ports. An internal
// first-fit model of the free-segment and live tables predicts each result.
// The monitor checks every status and block index in order.
// ============================================================================
`default_nettype none

module tb import ffba_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [16:0] addr;
        logic [16:0] size;
        logic        func;
    } alloc_req_t;

    typedef struct packed {
        logic [15:0] index;
        logic [2:0]  status;
    } alloc_rsp_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic [16:0] cfg_wdata = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;  // func[0], size_blocks[17:1], addr_block[34:18]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;       // status[2:0], block_index[18:3]

    first_fit_block_allocator_top DUT (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // ---- allocator model ----
    logic [16:0] heap_reg = 17'd65536;
    int          seg_start [MAX_FREE_SEGS];
    int          seg_len   [MAX_FREE_SEGS];
    int          seg_count = 0;
    bit          heap_set = 0;
    int          owned_start [MAX_LIVE_ALLOCS];
    int          owned_len   [MAX_LIVE_ALLOCS];
    bit          owned       [MAX_LIVE_ALLOCS];

    alloc_req_t  pending_reqs[$];
    alloc_rsp_t  expected_rsps[$];
    int          mismatches = 0;
    int          idle_cycles = 0;

    initial foreach (owned[k]) owned[k] = 0;

    function automatic alloc_rsp_t model_alloc(int size);
        alloc_rsp_t r;
        int slot;
        int base;
        r = '{status: ST_NO_FIT, index: '0};
        if (!heap_set) begin
            heap_set = 1;
            seg_count = 0;
            if (heap_reg != 0) begin
                seg_start[0] = 0;
                seg_len[0] = (heap_reg > 17'd65536) ? 65536 : int'(heap_reg);
                seg_count = 1;
            end
        end
        if (size == 0) return r;
        slot = MAX_LIVE_ALLOCS;
        for (int k = MAX_LIVE_ALLOCS - 1; k >= 0; k--)
            if (!owned[k]) slot = k;
        if (slot == MAX_LIVE_ALLOCS) begin
            r.status = ST_FULL;
            return r;
        end
        for (int i = 0; i < seg_count; i++) begin
            if (seg_len[i] >= size) begin
                base = seg_start[i];
                if (seg_len[i] == size) begin
                    for (int j = i; j + 1 < seg_count; j++) begin
                        seg_start[j] = seg_start[j + 1];
                        seg_len[j] = seg_len[j + 1];
                    end
                    seg_count--;
                end else begin
                    seg_start[i] = base + size;
                    seg_len[i] -= size;
                end
                owned_start[slot] = base;
                owned_len[slot] = size;
                owned[slot] = 1;
                r.status = ST_OK;
                r.index = base[15:0];
                return r;
            end
        end
        return r;
    endfunction

    function automatic logic [2:0] model_free(int addr);
        int slot;
        int len;
        int p;
        bit join_lo;
        bit join_hi;
        if (addr >= int'(heap_reg)) return ST_RANGE;
        slot = MAX_LIVE_ALLOCS;
        for (int k = MAX_LIVE_ALLOCS - 1; k >= 0; k--)
            if (owned[k] && owned_start[k] == addr) slot = k;
        if (slot == MAX_LIVE_ALLOCS) return ST_NOT_ALLOC;
        len = owned_len[slot];
        p = 0;
        while (p < seg_count && seg_start[p] < addr) p++;
        join_lo = p > 0 && seg_start[p - 1] + seg_len[p - 1] == addr;
        join_hi = p < seg_count && addr + len == seg_start[p];
        if (join_lo && join_hi) begin
            seg_len[p - 1] += len + seg_len[p];
            for (int j = p; j + 1 < seg_count; j++) begin
                seg_start[j] = seg_start[j + 1];
                seg_len[j] = seg_len[j + 1];
            end
            seg_count--;
        end else if (join_lo) begin
            seg_len[p - 1] += len;
        end else if (join_hi) begin
            seg_start[p] = addr;
            seg_len[p] += len;
        end else begin
            if (seg_count >= MAX_FREE_SEGS) return ST_FULL;
            for (int j = seg_count; j > p; j--) begin
                seg_start[j] = seg_start[j - 1];
                seg_len[j] = seg_len[j - 1];
            end
            seg_start[p] = addr;
            seg_len[p] = len;
            seg_count++;
        end
        owned[slot] = 0;
        return ST_OK;
    endfunction

    // ---- driver ----
    int burst_left = 1;
    int gap_left = 0;

    always @(posedge aclk) begin
        alloc_req_t q;
        alloc_rsp_t r;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                q = alloc_req_t'(s_tdata[34:0]);
                r = '{status: ST_OK, index: '0};
                if (q.func == FUNC_ALLOC) r = model_alloc(int'(q.size));
                else r.status = model_free(int'(q.addr));
                expected_rsps.push_back(r);
            end
            if (!s_tvalid || s_tready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end else if (pending_reqs.size() > 0) begin
                    q = pending_reqs.pop_front();
                    s_tdata <= {5'b0, q};
                    s_tvalid <= 1'b1;
                    burst_left--;
                    if (burst_left <= 0) begin
                        burst_left = $urandom_range(1, 30);
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
                    end
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // ---- receiver and monitor ----
    int stall_phase = 0;

    always @(posedge aclk) begin
        alloc_rsp_t got;
        alloc_rsp_t want;
        stall_phase++;
        case ((stall_phase / 700) % 3)
            0: m_tready <= 1'b1;
            1: m_tready <= ($urandom_range(0, 1) == 1);
            default: m_tready <= (stall_phase % 7) < 3;
        endcase
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata[18:0];
            if (expected_rsps.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %p", got);
            end else begin
                want = expected_rsps.pop_front();
                if (got.status !== want.status || got.index !== want.index) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: status exp %0d got %0d, index exp %0d got %0d",
                                 want.status, got.status, want.index, got.index);
                end
            end
        end
    end

    // ---- watchdog ----
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 3000) begin
            $display("first_fit_block_allocator_top regression: fail");
            $finish;
        end
    end

    // ---- stimulus ----
    task automatic send(logic func, int size, int addr);
        alloc_req_t q;
        q.func = func;
        q.size = size[16:0];
        q.addr = addr[16:0];
        pending_reqs.push_back(q);
    endtask

    task automatic drain();
        while (pending_reqs.size() > 0 || s_tvalid || expected_rsps.size() > 0)
            @(posedge aclk);
        repeat (40) @(posedge aclk);
    endtask

    task automatic write_heap(logic [16:0] value);
        @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        heap_reg = value;
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic random_phase(int count);
        int sel;
        int slot;
        int pick;
        repeat (count) begin
            while (pending_reqs.size() >= 2) @(posedge aclk);
            sel = $urandom_range(0, 99);
            if (sel < 45) begin
                pick = $urandom_range(0, 99);
                if (pick < 3) send(FUNC_ALLOC, 0, $urandom_range(0, 131071));
                else if (pick < 12) send(FUNC_ALLOC, $urandom_range(1, 65536),
                                         $urandom_range(0, 131071));
                else send(FUNC_ALLOC, $urandom_range(1, 6), $urandom_range(0, 131071));
            end else if (sel < 88) begin
                slot = $urandom_range(0, MAX_LIVE_ALLOCS - 1);
                pick = -1;
                for (int k = 0; k < MAX_LIVE_ALLOCS; k++)
                    if (pick < 0 && owned[(slot + k) % MAX_LIVE_ALLOCS])
                        pick = owned_start[(slot + k) % MAX_LIVE_ALLOCS];
                if (pick < 0) pick = $urandom_range(0, 64);
                send(FUNC_FREE, $urandom_range(0, 131071), pick);
            end else begin
                send(FUNC_FREE, $urandom_range(0, 131071), $urandom_range(0, 131071));
            end
        end
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        // oversized heap register: usable heap caps at 65536 blocks
        write_heap(17'd131071);
        send(FUNC_ALLOC, 0, 0);          // zero size, sets up the heap
        send(FUNC_ALLOC, 1, 0);
        send(FUNC_ALLOC, 65536, 0);      // no fit, only 65535 left
        send(FUNC_ALLOC, 65535, 0);      // exact fit empties the table
        send(FUNC_ALLOC, 1, 0);
        send(FUNC_FREE, 0, 1);           // insert into empty table
        send(FUNC_FREE, 0, 0);           // merge with upper neighbor
        send(FUNC_FREE, 0, 0);           // double free
        send(FUNC_FREE, 131071, 131071); // out of range
        send(FUNC_FREE, 0, 65535);       // in range, never allocated
        for (int k = 0; k < 16; k++) send(FUNC_ALLOC, 2, 0);
        send(FUNC_ALLOC, 2, 0);          // live table full
        send(FUNC_FREE, 0, 4);
        send(FUNC_FREE, 0, 8);
        send(FUNC_FREE, 0, 6);           // merge on both sides
        send(FUNC_FREE, 0, 30);          // merge with tail
        random_phase(300);
        drain();
        write_heap(17'd65536);
        random_phase(150);
        drain();
        write_heap(17'd1);
        random_phase(40);
        drain();
        write_heap(17'd0);
        random_phase(30);
        drain();
        write_heap(17'($urandom_range(16, 65535)));
        random_phase(180);
        drain();
        if (mismatches == 0 && expected_rsps.size() == 0)
            $display("first_fit_block_allocator_top regression: pass");
        else
            $display("first_fit_block_allocator_top regression: fail");
        $finish;
    end
endmodule

`default_nettype wire
